// ----- rtl/bcls_pkg.sv -----
// Types, widths and reset constants shared by the button press classifier.
package bcls_pkg;

  localparam int PinW          = 8;
  localparam int TimeW         = 32;
  localparam int CfgIdxW       = 2;
  localparam int CfgDataW      = 16;
  localparam int NumButtonsDef = 8;

  localparam logic [CfgDataW-1:0] DebounceRst = 16'd50;
  localparam logic [CfgDataW-1:0] LongRst     = 16'd1000;
  localparam logic [PinW-1:0]     MaskRst     = 8'hFF;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_DEBOUNCE = 2'd0,
    CFG_LONG     = 2'd1,
    CFG_MASK     = 2'd2
  } cfg_reg_e;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_DEBOUNCE = 3'd1,
    PH_SHORT    = 3'd2,
    PH_LONG     = 3'd3,
    PH_RELEASED = 3'd4
  } phase_e;

  typedef struct packed {
    logic short_ev;
    logic long_ev;
    logic released;
    logic held;
  } lane_res_t;

  typedef struct packed {
    logic [PinW-1:0] short_press_events;
    logic [PinW-1:0] long_press_events;
    logic [PinW-1:0] released_flags;
    logic [PinW-1:0] held_flags;
  } res_word_t;

endpackage

// ----- rtl/bcls_if.sv -----
// Handshake channel interfaces: tick input, result output and register writes.
interface bcls_in_if;
  logic                        valid;
  logic                        ready;
  logic [bcls_pkg::PinW-1:0]   pin_levels;
  logic [bcls_pkg::TimeW-1:0]  now_ms;

  modport source (output valid, output pin_levels, output now_ms, input ready);
  modport sink   (input valid, input pin_levels, input now_ms, output ready);
endinterface

interface bcls_out_if;
  logic                      valid;
  logic                      ready;
  logic [bcls_pkg::PinW-1:0] short_press_events;
  logic [bcls_pkg::PinW-1:0] long_press_events;
  logic [bcls_pkg::PinW-1:0] released_flags;
  logic [bcls_pkg::PinW-1:0] held_flags;

  modport source (output valid, output short_press_events, output long_press_events,
                  output released_flags, output held_flags, input ready);
  modport sink   (input valid, input short_press_events, input long_press_events,
                  input released_flags, input held_flags, output ready);
endinterface

interface bcls_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [bcls_pkg::CfgIdxW-1:0]  index;
  logic [bcls_pkg::CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/bcls_lane.sv -----
// One button lane: press phase machine with start time and threshold compares.
module bcls_lane (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          pressed_i,
  input  logic [bcls_pkg::TimeW-1:0]    now_i,
  input  logic [bcls_pkg::CfgDataW-1:0] debounce_i,
  input  logic [bcls_pkg::CfgDataW-1:0] long_i,
  output bcls_pkg::lane_res_t           res_o
);

  localparam int ExtW = bcls_pkg::TimeW - bcls_pkg::CfgDataW;

  bcls_pkg::phase_e             phase_q, phase_d;
  logic [bcls_pkg::TimeW-1:0]   start_q, start_d;
  logic [bcls_pkg::TimeW-1:0]   elapsed;
  logic                         deb_met, long_met;
  logic                         short_ev, long_ev;

  assign elapsed  = now_i - start_q;
  assign deb_met  = elapsed >= {{ExtW{1'b0}}, debounce_i};
  assign long_met = elapsed >= {{ExtW{1'b0}}, long_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= bcls_pkg::PH_IDLE;
      start_q <= '0;
    end else if (en_i) begin
      phase_q <= phase_d;
      start_q <= start_d;
    end
  end

  always_comb begin
    phase_d  = phase_q;
    start_d  = start_q;
    short_ev = 1'b0;
    long_ev  = 1'b0;
    case (phase_q)
      bcls_pkg::PH_DEBOUNCE: begin
        if (deb_met) begin
          if (pressed_i) begin
            phase_d = bcls_pkg::PH_SHORT;
            start_d = now_i;
          end else begin
            phase_d = bcls_pkg::PH_IDLE;
          end
        end
      end
      bcls_pkg::PH_SHORT: begin
        if (!pressed_i) begin
          short_ev = 1'b1;
          phase_d  = bcls_pkg::PH_RELEASED;
        end else if (long_met) begin
          long_ev = 1'b1;
          phase_d = bcls_pkg::PH_LONG;
        end
      end
      bcls_pkg::PH_LONG: begin
        if (!pressed_i) begin
          phase_d = bcls_pkg::PH_RELEASED;
        end
      end
      bcls_pkg::PH_RELEASED: begin
        phase_d = bcls_pkg::PH_IDLE;
      end
      default: begin
        if (pressed_i) begin
          phase_d = bcls_pkg::PH_DEBOUNCE;
          start_d = now_i;
        end else begin
          phase_d = bcls_pkg::PH_IDLE;
        end
      end
    endcase
  end

  assign res_o.short_ev = short_ev;
  assign res_o.long_ev  = long_ev;
  assign res_o.released = phase_d == bcls_pkg::PH_RELEASED;
  assign res_o.held     = (phase_d == bcls_pkg::PH_SHORT) || (phase_d == bcls_pkg::PH_LONG);

  a_short_from_short: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && short_ev |-> phase_q == bcls_pkg::PH_SHORT && !pressed_i)
    else $error("short event outside short press phase");

  a_release_one_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && phase_q == bcls_pkg::PH_RELEASED |=> phase_q == bcls_pkg::PH_IDLE)
    else $error("released phase lasted more than one tick");

  a_hold_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en_i |=> phase_q == $past(phase_q) && start_q == $past(start_q))
    else $error("lane state moved without a tick");

endmodule

// ----- rtl/bcls_merge.sv -----
// Merge of lane results into one result word, held in a two-entry output queue.
module bcls_merge #(
  parameter int NUM_LANES = bcls_pkg::NumButtonsDef
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 push_i,
  output logic                                 ready_o,
  input  bcls_pkg::lane_res_t [NUM_LANES-1:0]  lanes_i,
  bcls_out_if.source                           out_o
);

  bcls_pkg::res_word_t word;
  bcls_pkg::res_word_t slot_q [2];
  logic                wr_ptr_q, rd_ptr_q;
  logic [1:0]          count_q;
  logic                push, pop;

  for (genvar i = 0; i < bcls_pkg::PinW; i++) begin : g_bits
    if (i < NUM_LANES) begin : g_lane
      assign word.short_press_events[i] = lanes_i[i].short_ev;
      assign word.long_press_events[i]  = lanes_i[i].long_ev;
      assign word.released_flags[i]     = lanes_i[i].released;
      assign word.held_flags[i]         = lanes_i[i].held;
    end else begin : g_none
      assign word.short_press_events[i] = 1'b0;
      assign word.long_press_events[i]  = 1'b0;
      assign word.released_flags[i]     = 1'b0;
      assign word.held_flags[i]         = 1'b0;
    end
  end

  assign ready_o = count_q != 2'd2;
  assign push    = push_i && ready_o;
  assign pop     = out_o.valid && out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop) rd_ptr_q <= ~rd_ptr_q;
      if (push && !pop) begin
        count_q <= count_q + 2'd1;
      end else if (pop && !push) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) slot_q[wr_ptr_q] <= word;
  end

  assign out_o.valid              = count_q != 2'd0;
  assign out_o.short_press_events = slot_q[rd_ptr_q].short_press_events;
  assign out_o.long_press_events  = slot_q[rd_ptr_q].long_press_events;
  assign out_o.released_flags     = slot_q[rd_ptr_q].released_flags;
  assign out_o.held_flags         = slot_q[rd_ptr_q].held_flags;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3)
    else $error("output queue overfilled");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !pop |=> count_q == $past(count_q) + 2'd1)
    else $error("word lost on push");

  a_ptr_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == 2'd0 || count_q == 2'd2) |-> wr_ptr_q == rd_ptr_q)
    else $error("queue pointers out of step with count");

endmodule

// ----- rtl/button_press_classifier.sv -----
// Top level: registers, per-button lanes and result merge.
// A result word is formed from its tick word and registered in the output queue.
// One tick per cycle unless the output queue is full; all buttons update in parallel.
// A two-entry output queue lets ticks be taken while one result waits.
// Reset: every button idle, start times zero, thresholds 50 and 1000, mask 0xFF.
module button_press_classifier #(
  parameter int NUM_BUTTONS = bcls_pkg::NumButtonsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  bcls_in_if.sink     in_i,
  bcls_out_if.source  out_o,
  bcls_cfg_if.sink    cfg_i
);

  localparam int NumLanes = (NUM_BUTTONS < bcls_pkg::PinW) ? NUM_BUTTONS : bcls_pkg::PinW;

  logic [bcls_pkg::CfgDataW-1:0] debounce_q;
  logic [bcls_pkg::CfgDataW-1:0] long_q;
  logic [bcls_pkg::PinW-1:0]     mask_q;
  logic                          accept;
  logic                          merge_ready;
  bcls_pkg::lane_res_t [NumLanes-1:0] lane_res;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q <= bcls_pkg::DebounceRst;
      long_q     <= bcls_pkg::LongRst;
      mask_q     <= bcls_pkg::MaskRst;
    end else if (cfg_i.valid) begin
      case (bcls_pkg::cfg_reg_e'(cfg_i.index))
        bcls_pkg::CFG_DEBOUNCE: debounce_q <= cfg_i.data;
        bcls_pkg::CFG_LONG:     long_q     <= cfg_i.data;
        bcls_pkg::CFG_MASK:     mask_q     <= cfg_i.data[bcls_pkg::PinW-1:0];
        default: ;
      endcase
    end
  end

  assign in_i.ready = merge_ready;
  assign accept     = in_i.valid && merge_ready;

  for (genvar i = 0; i < NumLanes; i++) begin : g_lane
    bcls_lane u_lane (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .en_i       (accept),
      .pressed_i  (in_i.pin_levels[i] ^ mask_q[i]),
      .now_i      (in_i.now_ms),
      .debounce_i (debounce_q),
      .long_i     (long_q),
      .res_o      (lane_res[i])
    );
  end

  bcls_merge #(
    .NUM_LANES (NumLanes)
  ) u_merge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .ready_o (merge_ready),
    .lanes_i (lane_res),
    .out_o   (out_o)
  );

endmodule

// ----- test/button_press_classifier_tb.sv -----
// Self-checking testbench for the button press classifier: tick words in, flag words out.
`timescale 1ns / 100ps

module button_press_classifier_tb;
  import bcls_pkg::*;

  localparam cfg_reg_e CfgSpare = cfg_reg_e'(2'd3);

  logic clk = 1'b0;
  logic rst_n;

  bcls_in_if  tick_if ();
  bcls_out_if res_if ();
  bcls_cfg_if cfg_if ();

  button_press_classifier dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (tick_if),
    .out_o  (res_if),
    .cfg_i  (cfg_if)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Predictor state and register copies
  phase_e              button_phase [PinW];
  logic [TimeW-1:0]    phase_since  [PinW];
  logic [CfgDataW-1:0] debounce_limit;
  logic [CfgDataW-1:0] long_ms;
  logic [PinW-1:0]     low_mask;

  res_word_t expected_flags [$];
  res_word_t oldest_flags;
  int        error_count;

  // Stimulus control
  bit               sender_idle;
  bit               receiver_stall;
  int               hold_off_cycles;
  logic [PinW-1:0]  held_target;
  logic [TimeW-1:0] clock_ms;

  function automatic res_word_t classify_tick(input logic [PinW-1:0] pins,
                                              input logic [TimeW-1:0] now);
    res_word_t        r;
    logic             pressed;
    logic [TimeW-1:0] elapsed;
    r = '0;
    for (int b = 0; b < PinW; b++) begin
      pressed = low_mask[b] ? ~pins[b] : pins[b];
      elapsed = now - phase_since[b];
      case (button_phase[b])
        PH_DEBOUNCE: begin
          if (elapsed >= {16'd0, debounce_limit}) begin
            if (pressed) begin
              button_phase[b] = PH_SHORT;
              phase_since[b]  = now;
            end else begin
              button_phase[b] = PH_IDLE;
            end
          end
        end
        PH_SHORT: begin
          if (!pressed) begin
            r.short_press_events[b] = 1'b1;
            button_phase[b] = PH_RELEASED;
          end else if (elapsed >= {16'd0, long_ms}) begin
            r.long_press_events[b] = 1'b1;
            button_phase[b] = PH_LONG;
          end
        end
        PH_LONG: begin
          if (!pressed) button_phase[b] = PH_RELEASED;
        end
        PH_RELEASED: begin
          button_phase[b] = PH_IDLE;
        end
        default: begin
          if (pressed) begin
            button_phase[b] = PH_DEBOUNCE;
            phase_since[b]  = now;
          end else begin
            button_phase[b] = PH_IDLE;
          end
        end
      endcase
      r.released_flags[b] = (button_phase[b] == PH_RELEASED);
      r.held_flags[b]     = (button_phase[b] == PH_SHORT) || (button_phase[b] == PH_LONG);
    end
    return r;
  endfunction

  task automatic check_field(input string name, input logic [PinW-1:0] want,
                             input logic [PinW-1:0] got);
    if (got !== want) begin
      $error("%s: expected %02h, got %02h", name, want, got);
      error_count++;
    end
  endtask

  // Track register writes and tick words, check each result word in order
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_reg_e'(cfg_if.index))
          CFG_DEBOUNCE: debounce_limit = cfg_if.data;
          CFG_LONG:     long_ms        = cfg_if.data;
          CFG_MASK:     low_mask       = cfg_if.data[PinW-1:0];
          default: ;
        endcase
      end
      if (tick_if.valid && tick_if.ready)
        expected_flags.push_back(classify_tick(tick_if.pin_levels, tick_if.now_ms));
      if (res_if.valid && res_if.ready) begin
        if (expected_flags.size() == 0) begin
          $error("result word with no tick outstanding");
          error_count++;
        end else begin
          oldest_flags = expected_flags.pop_front();
          check_field("short_press_events", oldest_flags.short_press_events,
                      res_if.short_press_events);
          check_field("long_press_events", oldest_flags.long_press_events,
                      res_if.long_press_events);
          check_field("released_flags", oldest_flags.released_flags, res_if.released_flags);
          check_field("held_flags", oldest_flags.held_flags, res_if.held_flags);
        end
      end
    end
  end

  // Result receiver: random stalls and requested hold-offs
  initial begin
    int stall;
    wait (rst_n);
    forever begin
      if (hold_off_cycles != 0) begin
        repeat (hold_off_cycles) begin
          @(negedge clk);
          res_if.ready <= 1'b0;
        end
        hold_off_cycles = 0;
      end
      stall = receiver_stall ? $urandom_range(0, 4) : 0;
      repeat (stall) begin
        @(negedge clk);
        res_if.ready <= 1'b0;
      end
      @(negedge clk);
      res_if.ready <= 1'b1;
      do @(posedge clk); while (!res_if.valid);
    end
  end

  task automatic send_tick(input logic [PinW-1:0] pins, input logic [TimeW-1:0] now);
    int gap;
    gap = sender_idle ? $urandom_range(0, 4) : 0;
    repeat (gap) begin
      @(negedge clk);
      tick_if.valid <= 1'b0;
    end
    @(negedge clk);
    tick_if.valid      <= 1'b1;
    tick_if.pin_levels <= pins;
    tick_if.now_ms     <= now;
    do @(posedge clk); while (!tick_if.ready);
  endtask

  task automatic wait_all_results();
    @(negedge clk);
    tick_if.valid <= 1'b0;
    while (expected_flags.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CfgDataW-1:0] value);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk); while (!cfg_if.ready);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  function automatic logic [CfgDataW-1:0] pick_threshold();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (r < 5) return CfgDataW'($urandom_range(0, 500));
    return CfgDataW'($urandom_range(0, 40));
  endfunction

  // Held buttons flip now and then; a glitch bit is added on some words
  task automatic send_random_ticks(input int count);
    logic [PinW-1:0] pins;
    int              step_max;
    step_max = (int'(debounce_limit) + int'(long_ms)) / 6 + 2;
    for (int k = 0; k < count; k++) begin
      for (int b = 0; b < PinW; b++)
        if ($urandom_range(0, 11) == 0) held_target[b] = ~held_target[b];
      if ($urandom_range(0, 49) == 0) clock_ms = clock_ms + $urandom;
      else clock_ms = clock_ms + $urandom_range(0, step_max);
      pins = held_target ^ low_mask;
      if ($urandom_range(0, 9) == 0) pins = pins ^ (8'h01 << $urandom_range(0, 7));
      send_tick(pins, clock_ms);
    end
  endtask

  task automatic test_default_presses();
    send_tick(8'hFF, 32'd0);
    send_tick(8'hFE, 32'd100);
    send_tick(8'hFE, 32'd149);
    send_tick(8'hFC, 32'd150);
    send_tick(8'hFE, 32'd200);
    send_tick(8'hFE, 32'd1149);
    send_tick(8'hFE, 32'd1150);
    send_tick(8'hFF, 32'd1200);
    send_tick(8'hFF, 32'd1201);
    send_tick(8'hF7, 32'd2000);
    send_tick(8'hF7, 32'd2050);
    send_tick(8'hFF, 32'd2060);
    send_tick(8'hFF, 32'd2061);
    send_tick(8'h00, 32'd2100);
    send_tick(8'h00, 32'd2150);
    send_tick(8'hFF, 32'd2151);
    send_tick(8'hFF, 32'd2152);
    wait_all_results();
  endtask

  task automatic test_threshold_extremes();
    write_reg(CFG_DEBOUNCE, 16'd0);
    write_reg(CFG_LONG, 16'd0);
    write_reg(CFG_MASK, 16'hA500);
    write_reg(CfgSpare, 16'hFFFF);
    send_tick(8'h01, 32'hFFFF_FFFF);
    send_tick(8'h01, 32'h0000_0000);
    send_tick(8'h01, 32'h0000_0000);
    send_tick(8'h00, 32'h0000_0000);
    wait_all_results();
    write_reg(CFG_DEBOUNCE, 16'hFFFF);
    write_reg(CFG_LONG, 16'hFFFF);
    write_reg(CFG_MASK, 16'h000F);
    send_tick(8'hF0, 32'hFFFF_8000);
    send_tick(8'hF0, 32'h0000_7FFE);
    send_tick(8'hF0, 32'h0000_7FFF);
    send_tick(8'hF0, 32'h0001_7FFE);
    send_tick(8'h0F, 32'h0001_7FFF);
    wait_all_results();
  endtask

  task automatic test_random_sequences();
    held_target = '0;
    clock_ms    = $urandom;
    for (int phase = 0; phase < 9; phase++) begin
      sender_idle    = phase[0];
      receiver_stall = phase[1];
      write_reg(CFG_DEBOUNCE, pick_threshold());
      write_reg(CFG_LONG, pick_threshold());
      write_reg(CFG_MASK, {8'($urandom), 8'($urandom)});
      if (phase == 4) clock_ms = 32'hFFFF_F000;
      send_random_ticks(200);
      wait_all_results();
    end
  endtask

  task automatic test_output_hold_off();
    sender_idle     = 1'b0;
    receiver_stall  = 1'b0;
    hold_off_cycles = 150;
    send_random_ticks(40);
    wait_all_results();
  endtask

  task automatic test_sender_pause();
    sender_idle    = 1'b1;
    receiver_stall = 1'b1;
    send_random_ticks(30);
    wait_all_results();
    send_random_ticks(30);
    wait_all_results();
  endtask

  initial begin
    rst_n              = 1'b0;
    tick_if.valid      = 1'b0;
    tick_if.pin_levels = '0;
    tick_if.now_ms     = '0;
    res_if.ready       = 1'b0;
    cfg_if.valid       = 1'b0;
    cfg_if.index       = CFG_DEBOUNCE;
    cfg_if.data        = '0;
    debounce_limit     = DebounceRst;
    long_ms            = LongRst;
    low_mask           = MaskRst;
    for (int b = 0; b < PinW; b++) begin
      button_phase[b] = PH_IDLE;
      phase_since[b]  = '0;
    end
    error_count     = 0;
    sender_idle     = 1'b1;
    receiver_stall  = 1'b1;
    hold_off_cycles = 0;
    held_target     = '0;
    clock_ms        = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_default_presses();
    test_threshold_extremes();
    test_random_sequences();
    test_output_hold_off();
    test_sender_pause();

    if (error_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
